// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL modules; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// ante |-> cons, checked on every rising edge outside reset
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// ante |=> cons, checked on every rising edge outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define ASSERT_SAME(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/i2ctrf_pkg.sv =====
// ----------------------------------------------------------------------------
// i2ctrf_pkg
// Shared constants and types of the byte-bus target register file.
// ----------------------------------------------------------------------------
package i2ctrf_pkg;

    localparam int REGISTER_COUNT = 16;
    localparam int IDX_W          = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int PTR_W          = 8;
    localparam int CFG_W          = 16;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(REGISTER_COUNT - 1);
    localparam logic [PTR_W:0]   COUNT_EXT = (PTR_W + 1)'(REGISTER_COUNT);

    localparam logic [CFG_W-1:0] TEMP_RESET = 16'd255;
    localparam logic [CFG_W-1:0] HUM_RESET  = 16'd600;
    localparam logic [7:0]       FILL_BYTE  = 8'hFF;

    // command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_SET_POINTER = 2'd0,
        CMD_WRITE_DATA  = 2'd1,
        CMD_READ        = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_TEMPERATURE = 1'b0,
        CFG_HUMIDITY    = 1'b1
    } cfg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic set_ptr;
        logic wr_data;
        logic start_read;
        logic emit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic emit_last;
    } dp_status_t;

endpackage

// ===== rtl/i2ctrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2ctrf_ctrl
// Controller: decodes accepted words and sequences the read burst.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2ctrf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  i2ctrf_pkg::cmd_t       cmd_code,
    input  i2ctrf_pkg::dp_status_t status,
    output i2ctrf_pkg::dp_cmd_t    cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd_code)
                        i2ctrf_pkg::CMD_SET_POINTER: cmd.set_ptr = 1'b1;
                        i2ctrf_pkg::CMD_WRITE_DATA:  cmd.wr_data = 1'b1;
                        i2ctrf_pkg::CMD_READ: begin
                            cmd.start_read = 1'b1;
                            state_next     = ST_STREAM;
                        end
                        default: ;  // unused code: dropped
                    endcase
                end
            end
            ST_STREAM: begin
                cmd.emit = status.out_free;
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEXT(a_read_enters_stream, aclk, aresetn, accept && (cmd_code == i2ctrf_pkg::CMD_READ), state_reg == ST_STREAM)
    `ASSERT_SAME(a_emit_needs_slot, aclk, aresetn, cmd.emit, status.out_free && (state_reg == ST_STREAM))
    `ASSERT_NEXT(a_stream_holds, aclk, aresetn, (state_reg == ST_STREAM) && !(cmd.emit && status.emit_last), state_reg == ST_STREAM)

endmodule

// ===== rtl/i2ctrf_dp.sv =====
// ----------------------------------------------------------------------------
// i2ctrf_dp
// Datapath: register store, pointer, sensor words, read index, output word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2ctrf_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  i2ctrf_pkg::dp_cmd_t              cmd,
    output i2ctrf_pkg::dp_status_t           status,
    input  logic [7:0]                       bus_byte,
    input  logic                             cfg_wr_en,
    input  i2ctrf_pkg::cfg_idx_t             cfg_index,
    input  logic [i2ctrf_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,
    output logic                             m_tlast
);

    logic [7:0]                        store_reg [i2ctrf_pkg::REGISTER_COUNT];
    logic [i2ctrf_pkg::PTR_W-1:0]      ptr_reg;
    logic [i2ctrf_pkg::CFG_W-1:0]      temp_reg;
    logic [i2ctrf_pkg::CFG_W-1:0]      hum_reg;
    logic [i2ctrf_pkg::IDX_W-1:0]      rd_idx_reg;
    logic                              rd_ovf_reg;
    logic                              out_valid_reg;
    logic [7:0]                        out_data_reg;
    logic                              out_last_reg;

    logic                              ptr_in_range;
    logic [i2ctrf_pkg::IDX_W-1:0]      ptr_idx;

    assign ptr_in_range     = {1'b0, ptr_reg} < i2ctrf_pkg::COUNT_EXT;
    assign ptr_idx          = ptr_reg[i2ctrf_pkg::IDX_W-1:0];
    assign status.out_free  = !out_valid_reg || m_tready;
    // pointer past the store sends a single fill byte
    assign status.emit_last = rd_ovf_reg || (rd_idx_reg == i2ctrf_pkg::LAST_IDX);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg <= i2ctrf_pkg::TEMP_RESET;
            hum_reg  <= i2ctrf_pkg::HUM_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                i2ctrf_pkg::CFG_TEMPERATURE: temp_reg <= cfg_wdata;
                i2ctrf_pkg::CFG_HUMIDITY:    hum_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // store and pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < i2ctrf_pkg::REGISTER_COUNT; i++) begin
                store_reg[i] <= '0;
            end
            ptr_reg <= '0;
        end else begin
            if (cmd.set_ptr) begin
                ptr_reg <= bus_byte;
            end
            if (cmd.wr_data && ptr_in_range) begin
                store_reg[ptr_idx] <= bus_byte;
                ptr_reg            <= ptr_reg + 1'b1;
            end
            if (cmd.start_read) begin
                store_reg[0] <= temp_reg[15:8];
                store_reg[1] <= temp_reg[7:0];
                store_reg[2] <= hum_reg[15:8];
                store_reg[3] <= hum_reg[7:0];
            end
        end
    end

    // read index: payload, loaded at every read start
    always_ff @(posedge aclk) begin
        if (cmd.start_read) begin
            rd_idx_reg <= ptr_idx;
            rd_ovf_reg <= !ptr_in_range;
        end else if (cmd.emit) begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= rd_ovf_reg ? i2ctrf_pkg::FILL_BYTE : store_reg[rd_idx_reg];
            out_last_reg <= status.emit_last;
        end
    end

    `ASSERT_NEXT(a_drop_keeps_ptr, aclk, aresetn, cmd.wr_data && !ptr_in_range, $stable(ptr_reg))
    `ASSERT_NEXT(a_emit_fills_out, aclk, aresetn, cmd.emit, m_tvalid && (m_tlast == $past(status.emit_last)))
    `ASSERT_NEXT(a_ovf_sends_fill, aclk, aresetn, cmd.emit && rd_ovf_reg, (m_tdata == i2ctrf_pkg::FILL_BYTE) && m_tlast)

endmodule

// ===== rtl/i2c_target_register_file.sv =====
// ----------------------------------------------------------------------------
// i2c_target_register_file
// Byte-bus target register map with auto-increment pointer and sensor bytes.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata            | tuser     | tlast
//  ----------+-----+------------------+-----------+-----------
//  s_ (cmd)  | in  | [7:0] bus_byte   | [1:0] cmd | -
//  m_ (read) | out | [7:0] read_byte  | -         | last_byte
//  cfg_      | in  | cfg_wdata[15:0] at cfg_index, on cfg_wr_en
//
// A read is accepted, then streams 16 - pointer bytes (one fill byte if
// the pointer is past the store) at one per cycle from the store;
// m_tready low stalls the stream.
// s_tready is low while a burst streams; the last byte may still wait in
// the output register while the next word is taken.
// Reset clears the store and pointer and loads the config reset values.
// ----------------------------------------------------------------------------
module i2c_target_register_file (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] bus_byte
    input  logic [1:0]                   s_tuser,   // [1:0] cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] read_byte
    output logic                         m_tlast,
    input  logic                         cfg_wr_en,
    input  logic [0:0]                   cfg_index,
    input  logic [i2ctrf_pkg::CFG_W-1:0] cfg_wdata
);

    i2ctrf_pkg::dp_cmd_t    cmd;
    i2ctrf_pkg::dp_status_t status;

    i2ctrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd_code (i2ctrf_pkg::cmd_t'(s_tuser)),
        .status   (status),
        .cmd      (cmd)
    );

    i2ctrf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .bus_byte  (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (i2ctrf_pkg::cfg_idx_t'(cfg_index)),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== bench/i2c_target_register_file_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_target_register_file_tb
// Self-checking bench for the byte-bus target register file. Bus words
// (pointer loads, data writes, reads, unused codes) are streamed in with
// random gaps. A mirror of the store, pointer and sensor words predicts every
// read byte, and the read stream is checked word by word under random
// back-pressure. Sensor words are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module i2c_target_register_file_tb;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;   // no operation behind this code
    localparam int         STALL_LIMIT = 2000;   // cycles with no handshake at all
    localparam int         SETTLE      = 24;     // > one full read burst
    localparam int         PHASE_WORDS = 18;
    localparam int         REPORT_MAX  = 10;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } bus_word_t;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       last;
    } read_beat_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic [1:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;
    logic                           cfg_wr_en = 1'b0;
    logic [0:0]                     cfg_index = '0;
    logic [i2ctrf_pkg::CFG_W-1:0]   cfg_wdata = '0;

    // stimulus and prediction
    bus_word_t                      words_to_send[$];
    read_beat_t                     pending_read_bytes[$];
    logic [7:0]                     reg_mirror[i2ctrf_pkg::REGISTER_COUNT];
    logic [7:0]                     ptr_mirror;
    logic [i2ctrf_pkg::CFG_W-1:0]   temp_word;
    logic [i2ctrf_pkg::CFG_W-1:0]   hum_word;

    // bookkeeping
    int                  words_queued  = 0;
    int                  words_taken   = 0;
    int                  bytes_checked = 0;
    int                  cfg_writes    = 0;
    int                  error_count   = 0;
    int                  idle_cycles   = 0;
    bit                  s_taken       = 1'b0;
    bit                  m_taken       = 1'b0;
    bit                  s_quiet       = 1'b0;
    bit                  m_quiet       = 1'b0;
    int                  s_gap         = 0;
    int                  m_wait        = 0;
    bus_word_t           next_word;
    read_beat_t          want;

    i2c_target_register_file uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // wait length for the next word; quiet stretches give back-to-back traffic
    function automatic int draw_wait(ref bit quiet);
        if ($urandom_range(0, 15) == 0)
            quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic reset_mirror();
        for (int i = 0; i < i2ctrf_pkg::REGISTER_COUNT; i++)
            reg_mirror[i] = '0;
        ptr_mirror = '0;
        temp_word  = i2ctrf_pkg::TEMP_RESET;
        hum_word   = i2ctrf_pkg::HUM_RESET;
    endtask

    // apply one accepted bus word to the mirror, queue the read bytes it causes
    task automatic track_bus_word(logic [1:0] cmd, logic [7:0] data);
        read_beat_t beat;
        case (cmd)
            i2ctrf_pkg::CMD_SET_POINTER: begin
                ptr_mirror = data;
            end
            i2ctrf_pkg::CMD_WRITE_DATA: begin
                if (ptr_mirror < i2ctrf_pkg::REGISTER_COUNT) begin
                    reg_mirror[ptr_mirror] = data;
                    ptr_mirror = 8'(ptr_mirror + 1);
                end
            end
            i2ctrf_pkg::CMD_READ: begin
                reg_mirror[0] = temp_word[15:8];
                reg_mirror[1] = temp_word[7:0];
                reg_mirror[2] = hum_word[15:8];
                reg_mirror[3] = hum_word[7:0];
                if (ptr_mirror >= i2ctrf_pkg::REGISTER_COUNT) begin
                    beat.rd_byte = i2ctrf_pkg::FILL_BYTE;
                    beat.last    = 1'b1;
                    pending_read_bytes = {pending_read_bytes, beat};
                end else begin
                    for (int i = ptr_mirror; i < i2ctrf_pkg::REGISTER_COUNT; i++) begin
                        beat.rd_byte = reg_mirror[i];
                        beat.last    = (i == i2ctrf_pkg::REGISTER_COUNT - 1);
                        pending_read_bytes = {pending_read_bytes, beat};
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // driver: one bus word at a time, random gap after each
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_taken) begin
                // hold the word until it is taken
            end else if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap--;
            end else if (words_to_send.size() > 0) begin
                next_word = words_to_send.pop_front();
                s_tvalid  <= 1'b1;
                s_tuser   <= next_word.cmd;
                s_tdata   <= next_word.data;
                s_gap     = draw_wait(s_quiet);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // read side back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_taken)
                m_wait = draw_wait(m_quiet);
            if (m_wait > 0) begin
                m_tready <= 1'b0;
                m_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: mirror update, read stream check, watchdog
    always @(posedge aclk) begin
        s_taken = aresetn && s_tvalid && s_tready;
        m_taken = aresetn && m_tvalid && m_tready;
        if (!aresetn) begin
            reset_mirror();
            idle_cycles = 0;
        end else begin
            if (cfg_wr_en) begin
                case (i2ctrf_pkg::cfg_idx_t'(cfg_index))
                    i2ctrf_pkg::CFG_TEMPERATURE: temp_word = cfg_wdata;
                    i2ctrf_pkg::CFG_HUMIDITY:    hum_word  = cfg_wdata;
                    default: ;
                endcase
            end
            // check before predicting: a read taken now cannot have bytes out yet
            if (m_taken) begin
                bytes_checked++;
                if (pending_read_bytes.size() == 0) begin
                    if (error_count < REPORT_MAX)
                        $display("ERROR: unexpected read word data=%02h last=%0b",
                                 m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = pending_read_bytes.pop_front();
                    if (m_tdata !== want.rd_byte) begin
                        if (error_count < REPORT_MAX)
                            $display("ERROR: read byte #%0d expected %02h got %02h",
                                     bytes_checked, want.rd_byte, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        if (error_count < REPORT_MAX)
                            $display("ERROR: read byte #%0d last expected %0b got %0b",
                                     bytes_checked, want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (s_taken) begin
                track_bus_word(s_tuser, s_tdata);
                words_taken++;
            end
            if (s_taken || m_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles, %0d words in flight",
                         idle_cycles, words_queued - words_taken);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    task automatic queue_word(logic [1:0] cmd, logic [7:0] data);
        bus_word_t w;
        w.cmd  = cmd;
        w.data = data;
        words_to_send = {words_to_send, w};
        words_queued++;
    endtask

    task automatic wait_idle();
        while (!(words_taken == words_queued && pending_read_bytes.size() == 0))
            @(negedge aclk);
        // last word may have been a write still in the pipe
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_sensor_cfg(i2ctrf_pkg::cfg_idx_t idx,
                                    logic [i2ctrf_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    // mostly pointer-then-data or pointer-then-read transactions, some noise
    task automatic queue_random_phase(int n_words);
        int         start;
        int         kind;
        logic [7:0] ptr;
        start = words_queued;
        while (words_queued - start < n_words) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 4) == 0)
                ptr = 8'($urandom_range(i2ctrf_pkg::REGISTER_COUNT, 255));
            else
                ptr = 8'($urandom_range(0, i2ctrf_pkg::REGISTER_COUNT - 1));
            if (kind == 0) begin
                queue_word(2'($urandom_range(0, 3)), 8'($urandom));
            end else if (kind < 6) begin
                queue_word(i2ctrf_pkg::CMD_SET_POINTER, ptr);
                repeat ($urandom_range(1, 5))
                    queue_word(i2ctrf_pkg::CMD_WRITE_DATA, 8'($urandom));
            end else if (kind < 9) begin
                queue_word(i2ctrf_pkg::CMD_SET_POINTER, ptr);
                queue_word(i2ctrf_pkg::CMD_READ, 8'($urandom));
            end else begin
                queue_word(i2ctrf_pkg::CMD_READ, 8'($urandom));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, sensor words at reset values
        queue_word(i2ctrf_pkg::CMD_READ, 8'h00);         // whole store from byte 0
        queue_word(i2ctrf_pkg::CMD_SET_POINTER, 8'hFF);
        queue_word(i2ctrf_pkg::CMD_READ, 8'hFF);         // pointer past the store
        queue_word(i2ctrf_pkg::CMD_SET_POINTER, 8'(i2ctrf_pkg::REGISTER_COUNT));
        queue_word(i2ctrf_pkg::CMD_WRITE_DATA, 8'hAA);   // dropped
        queue_word(i2ctrf_pkg::CMD_READ, 8'h00);
        queue_word(i2ctrf_pkg::CMD_SET_POINTER, 8'(i2ctrf_pkg::REGISTER_COUNT - 1));
        queue_word(i2ctrf_pkg::CMD_WRITE_DATA, 8'hFF);
        queue_word(i2ctrf_pkg::CMD_WRITE_DATA, 8'h00);   // pointer now past the end
        queue_word(i2ctrf_pkg::CMD_SET_POINTER, 8'(i2ctrf_pkg::REGISTER_COUNT - 1));
        queue_word(i2ctrf_pkg::CMD_READ, 8'h00);         // single byte burst
        queue_word(i2ctrf_pkg::CMD_SET_POINTER, 8'h02);
        queue_word(i2ctrf_pkg::CMD_WRITE_DATA, 8'h55);   // sensor bytes, overwritten by read
        queue_word(i2ctrf_pkg::CMD_WRITE_DATA, 8'hAA);
        queue_word(i2ctrf_pkg::CMD_SET_POINTER, 8'h00);
        queue_word(i2ctrf_pkg::CMD_READ, 8'h00);
        queue_word(CMD_UNUSED, 8'hA5);                   // ignored
        queue_word(i2ctrf_pkg::CMD_READ, 8'h5A);
        queue_word(i2ctrf_pkg::CMD_SET_POINTER, 8'h80);
        queue_word(i2ctrf_pkg::CMD_READ, 8'h00);
        queue_word(i2ctrf_pkg::CMD_SET_POINTER, 8'h04);
        queue_word(i2ctrf_pkg::CMD_WRITE_DATA, 8'hFF);
        queue_word(i2ctrf_pkg::CMD_READ, 8'h00);         // pointer left at 5
        wait_idle();

        write_sensor_cfg(i2ctrf_pkg::CFG_TEMPERATURE, 16'h0000);
        write_sensor_cfg(i2ctrf_pkg::CFG_HUMIDITY, 16'h0000);
        queue_random_phase(PHASE_WORDS);
        wait_idle();

        write_sensor_cfg(i2ctrf_pkg::CFG_TEMPERATURE, 16'hFFFF);
        write_sensor_cfg(i2ctrf_pkg::CFG_HUMIDITY, 16'hFFFF);
        queue_random_phase(PHASE_WORDS);
        wait_idle();

        write_sensor_cfg(i2ctrf_pkg::CFG_TEMPERATURE, 16'hFFFF);
        write_sensor_cfg(i2ctrf_pkg::CFG_HUMIDITY, 16'h0000);
        queue_random_phase(PHASE_WORDS);
        wait_idle();

        repeat (2) begin
            write_sensor_cfg(i2ctrf_pkg::CFG_TEMPERATURE, 16'($urandom));
            write_sensor_cfg(i2ctrf_pkg::CFG_HUMIDITY, 16'($urandom));
            queue_random_phase(PHASE_WORDS);
            wait_idle();
        end

        if (pending_read_bytes.size() != 0) begin
            $display("ERROR: %0d read bytes never arrived", pending_read_bytes.size());
            error_count += pending_read_bytes.size();
        end
        $display("Sent %0d bus words, checked %0d read bytes, %0d sensor word writes",
                 words_taken, bytes_checked, cfg_writes);
        $display("Mismatches: %0d", error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
